// File: rtl/core/pcse_pkg.sv
// shared constants, codes and state type of the prime count and sum engine
package pcse_pkg;

  // default argument width and fixed result widths
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 61;
  localparam int OP_WIDTH        = 2;
  localparam int ST_WIDTH        = 2;

  // job kinds
  typedef enum logic [OP_WIDTH-1:0] {
    OP_SUM    = 2'd0,
    OP_SLEEP  = 2'd1,
    OP_PRIMES = 2'd2,
    OP_UNSUP  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [ST_WIDTH-1:0] {
    ST_DONE        = 2'd0,
    ST_NEGATIVE    = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_SUM,
    S_SQRT,
    S_INIT_LO,
    S_INIT_HI_WR,
    S_DIV,
    S_P_RD0,
    S_P_RD1,
    S_P_CHK,
    S_HI_CHK,
    S_HI_Q,
    S_HI_Q2,
    S_HI_SUB,
    S_HI_WR,
    S_LO_CHK,
    S_LO_Q,
    S_LO_SUB,
    S_LO_WR,
    S_NEXT_P,
    S_FIN_RD,
    S_FIN,
    S_DONE
  } state_t;

endpackage

// File: rtl/core/pcse_ram.sv
// generic simple dual-port ram with registered read
module pcse_ram #(
  parameter int WIDTH      = 32,
  parameter int ADDR_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_WIDTH-1:0] wr_addr,
  input  logic [WIDTH-1:0]      wr_data,
  input  logic [ADDR_WIDTH-1:0] rd_addr,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem_r [0:(64'd1 << ADDR_WIDTH) - 64'd1];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

// File: rtl/core/prime_count_and_sum_engine_core.sv
// prime count and sum engine: job sequencer with bit-serial divide, root and multiply
//
//   channel | ports  | tdata (low bit up)   | tuser (low bit up)
//   --------+--------+----------------------+--------------------
//   jobs    | in_*   | value_in             | operation
//   results | out_*  | value_out            | status
//
// failures and sleep go straight to the result hand-off; sum shifts in one multiplier bit
// per cycle. count primes takes bit-serial root steps to find r = floor(sqrt(n)), fills the
// two count tables, then updates them in the partial-count sieve, each quotient coming
// from the one-bit-per-cycle divider.
// one job at a time; the next job is taken once the result sits in the output register.
// synchronous reset clears only control state; each prime count job rebuilds the tables.
module prime_count_and_sum_engine_core #(
  parameter int  VALUE_WIDTH    = pcse_pkg::VALUE_WIDTH_DEF,
  localparam int IN_DATA_WIDTH  = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_WIDTH = ((pcse_pkg::OUT_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_DATA_WIDTH-1:0]      in_tdata,   // value_in
  input  logic [pcse_pkg::OP_WIDTH-1:0] in_tuser,   // operation
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_DATA_WIDTH-1:0]     out_tdata,  // value_out
  output logic [pcse_pkg::ST_WIDTH-1:0] out_tuser   // status
);

  import pcse_pkg::*;

  localparam int W    = VALUE_WIDTH;
  localparam int H    = (W + 1) / 2;
  localparam int AW   = W / 2;
  localparam int CNTW = $clog2(W + 1);
  localparam int XW   = (W > OUT_WIDTH) ? W : OUT_WIDTH;

  // sequencer and loop registers
  state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]      n_r, n_nxt;
  logic [AW-1:0]     r_r, r_nxt;
  logic [AW:0]       p_r, p_nxt, i_r, i_nxt, v_r, v_nxt;
  logic [W-1:0]      d_r, d_nxt;
  logic [W:0]        sq_r, sq_nxt;
  logic [W-1:0]      below_r, below_nxt, cur_r, cur_nxt;
  logic              sel_lo_r, sel_lo_nxt;

  // divider, root and multiplier registers
  logic [W-1:0]      dq_r, dq_nxt, drem_r, drem_nxt, dden_r, dden_nxt;
  logic [H+1:0]      srem_r, srem_nxt;
  logic [H-1:0]      sroot_r, sroot_nxt;
  logic [2*H-1:0]    ssrc_r, ssrc_nxt;
  logic [W-1:0]      sa_r, sa_nxt;
  logic [OUT_WIDTH-1:0] sb_r, sb_nxt;

  // result and output registers
  status_t              res_status_r, res_status_nxt;
  logic [OUT_WIDTH-1:0] res_value_r, res_value_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [OUT_WIDTH-1:0] out_value_r, out_value_nxt;

  // table ports
  logic          lo_we, hi_we;
  logic [AW-1:0] lo_waddr, hi_waddr, lo_raddr, hi_raddr;
  logic [W-1:0]  lo_wdata, hi_wdata, lo_rdata, hi_rdata;

  // step logic
  logic [W:0]      div_sh;
  logic            div_ge;
  logic [H+3:0]    sqrt_sh, sqrt_trial;
  logic            sqrt_ge;
  logic [H-1:0]    sqrt_root_step;
  logic [OUT_WIDTH-1:0] sum_step;
  logic [W-1:0]    raw, raw_p1, sum_a_init, sum_b_init;
  logic [XW-1:0]   b_ext, cnt_ext;
  op_t             op;

  // partial counts: lo holds pi(v) for v <= r, hi holds pi(n/i) for i <= r
  pcse_ram #(.WIDTH(W), .ADDR_WIDTH(AW)) u_lo_ram (
    .clk     (clk),
    .wr_en   (lo_we),
    .wr_addr (lo_waddr),
    .wr_data (lo_wdata),
    .rd_addr (lo_raddr),
    .rd_data (lo_rdata)
  );

  pcse_ram #(.WIDTH(W), .ADDR_WIDTH(AW)) u_hi_ram (
    .clk     (clk),
    .wr_en   (hi_we),
    .wr_addr (hi_waddr),
    .wr_data (hi_wdata),
    .rd_addr (hi_raddr),
    .rd_data (hi_rdata)
  );

  // one restoring divide step per cycle
  assign div_sh = {drem_r, dq_r[W-1]};
  assign div_ge = div_sh >= {1'b0, dden_r};

  // one root digit per cycle
  assign sqrt_sh        = {srem_r, ssrc_r[2*H-1:2*H-2]};
  assign sqrt_trial     = (H + 4)'({sroot_r, 2'b01});
  assign sqrt_ge        = sqrt_sh >= sqrt_trial;
  assign sqrt_root_step = {sroot_r[H-2:0], sqrt_ge};

  // one multiplier bit per cycle, kept modulo the result width
  assign sum_step = {res_value_r[OUT_WIDTH-2:0], 1'b0} + (sa_r[W-1] ? sb_r : '0);

  // job decode
  assign op         = op_t'(in_tuser);
  assign raw        = in_tdata[W-1:0];
  assign raw_p1     = raw + W'(1);
  assign sum_a_init = raw[0] ? raw : (raw >> 1);
  assign sum_b_init = raw[0] ? (raw_p1 >> 1) : raw_p1;
  assign b_ext      = XW'(sum_b_init);
  assign cnt_ext    = XW'(hi_rdata);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_WIDTH'(out_value_r);
  assign out_tuser  = out_status_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ret_r        <= ret_nxt;
    cnt_r        <= cnt_nxt;
    n_r          <= n_nxt;
    r_r          <= r_nxt;
    p_r          <= p_nxt;
    i_r          <= i_nxt;
    v_r          <= v_nxt;
    d_r          <= d_nxt;
    sq_r         <= sq_nxt;
    below_r      <= below_nxt;
    cur_r        <= cur_nxt;
    sel_lo_r     <= sel_lo_nxt;
    dq_r         <= dq_nxt;
    drem_r       <= drem_nxt;
    dden_r       <= dden_nxt;
    srem_r       <= srem_nxt;
    sroot_r      <= sroot_nxt;
    ssrc_r       <= ssrc_nxt;
    sa_r         <= sa_nxt;
    sb_r         <= sb_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    r_nxt          = r_r;
    p_nxt          = p_r;
    i_nxt          = i_r;
    v_nxt          = v_r;
    d_nxt          = d_r;
    sq_nxt         = sq_r;
    below_nxt      = below_r;
    cur_nxt        = cur_r;
    sel_lo_nxt     = sel_lo_r;
    dq_nxt         = dq_r;
    drem_nxt       = drem_r;
    dden_nxt       = dden_r;
    srem_nxt       = srem_r;
    sroot_nxt      = sroot_r;
    ssrc_nxt       = ssrc_r;
    sa_nxt         = sa_r;
    sb_nxt         = sb_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    lo_we          = 1'b0;
    hi_we          = 1'b0;
    lo_waddr       = v_r[AW-1:0];
    hi_waddr       = i_r[AW-1:0];
    lo_wdata       = '0;
    hi_wdata       = '0;
    lo_raddr       = p_r[AW-1:0];
    hi_raddr       = i_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt          = raw;
          res_status_nxt = ST_DONE;
          res_value_nxt  = '0;
          state_nxt      = S_DONE;
          if (op == OP_UNSUP) begin
            res_status_nxt = ST_UNSUPPORTED;
          end else if (raw[W-1]) begin
            res_status_nxt = ST_NEGATIVE;
          end else begin
            unique case (op)
              OP_SUM: begin
                sa_nxt    = sum_a_init;
                sb_nxt    = b_ext[OUT_WIDTH-1:0];
                cnt_nxt   = CNTW'(W);
                state_nxt = S_SUM;
              end
              OP_PRIMES: begin
                if (raw >= W'(2)) begin
                  ssrc_nxt  = (2 * H)'(raw);
                  srem_nxt  = '0;
                  sroot_nxt = '0;
                  cnt_nxt   = CNTW'(H);
                  state_nxt = S_SQRT;
                end
              end
              default: begin
                // sleep completes at once
              end
            endcase
          end
        end
      end

      // n(n+1)/2 as (even factor / 2) times the other
      S_SUM: begin
        res_value_nxt = sum_step;
        sa_nxt        = sa_r << 1;
        cnt_nxt       = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          state_nxt = S_DONE;
        end
      end

      // floor square root, two bits of n per step
      S_SQRT: begin
        srem_nxt  = sqrt_ge ? (H + 2)'(sqrt_sh - sqrt_trial) : (H + 2)'(sqrt_sh);
        sroot_nxt = sqrt_root_step;
        ssrc_nxt  = ssrc_r << 2;
        cnt_nxt   = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          r_nxt     = sqrt_root_step[AW-1:0];
          v_nxt     = '0;
          state_nxt = S_INIT_LO;
        end
      end

      // lo[v] = v - 1, lo[0] = 0
      S_INIT_LO: begin
        lo_we    = 1'b1;
        lo_waddr = v_r[AW-1:0];
        lo_wdata = (v_r == '0) ? '0 : (W'(v_r) - W'(1));
        if (v_r == {1'b0, r_r}) begin
          i_nxt     = (AW + 1)'(1);
          dq_nxt    = n_r;
          drem_nxt  = '0;
          dden_nxt  = W'(1);
          cnt_nxt   = CNTW'(W);
          ret_nxt   = S_INIT_HI_WR;
          state_nxt = S_DIV;
        end else begin
          v_nxt = v_r + (AW + 1)'(1);
        end
      end

      // hi[i] = n/i - 1
      S_INIT_HI_WR: begin
        hi_we    = 1'b1;
        hi_waddr = i_r[AW-1:0];
        hi_wdata = dq_r - W'(1);
        if (i_r == {1'b0, r_r}) begin
          p_nxt  = (AW + 1)'(2);
          sq_nxt = (W + 1)'(4);
          if (r_r < AW'(2)) begin
            state_nxt = S_FIN_RD;
          end else begin
            state_nxt = S_P_RD0;
          end
        end else begin
          i_nxt     = i_r + (AW + 1)'(1);
          dq_nxt    = n_r;
          drem_nxt  = '0;
          dden_nxt  = W'(i_r + (AW + 1)'(1));
          cnt_nxt   = CNTW'(W);
          ret_nxt   = S_INIT_HI_WR;
          state_nxt = S_DIV;
        end
      end

      // shared divider, returns to the caller state
      S_DIV: begin
        drem_nxt = div_ge ? W'(div_sh - {1'b0, dden_r}) : W'(div_sh);
        dq_nxt   = {dq_r[W-2:0], div_ge};
        cnt_nxt  = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          state_nxt = ret_r;
        end
      end

      // fetch lo[p] and lo[p-1] to see whether p is prime
      S_P_RD0: begin
        lo_raddr  = p_r[AW-1:0];
        state_nxt = S_P_RD1;
      end

      S_P_RD1: begin
        lo_raddr  = AW'(p_r - (AW + 1)'(1));
        cur_nxt   = lo_rdata;
        state_nxt = S_P_CHK;
      end

      S_P_CHK: begin
        if (lo_rdata == cur_r) begin
          state_nxt = S_NEXT_P;
        end else begin
          below_nxt = lo_rdata;
          i_nxt     = (AW + 1)'(1);
          d_nxt     = W'(p_r);
          state_nxt = S_HI_CHK;
        end
      end

      // high table pass over i while n/i >= p*p
      S_HI_CHK: begin
        if (i_r <= {1'b0, r_r}) begin
          dq_nxt    = n_r;
          drem_nxt  = '0;
          dden_nxt  = W'(i_r);
          cnt_nxt   = CNTW'(W);
          ret_nxt   = S_HI_Q;
          state_nxt = S_DIV;
        end else begin
          v_nxt     = {1'b0, r_r};
          state_nxt = S_LO_CHK;
        end
      end

      S_HI_Q: begin
        if ((W + 1)'(dq_r) >= sq_r) begin
          if (d_r <= W'(r_r)) begin
            hi_raddr   = d_r[AW-1:0];
            sel_lo_nxt = 1'b0;
            state_nxt  = S_HI_SUB;
          end else begin
            dq_nxt    = n_r;
            drem_nxt  = '0;
            dden_nxt  = d_r;
            cnt_nxt   = CNTW'(W);
            ret_nxt   = S_HI_Q2;
            state_nxt = S_DIV;
          end
        end else begin
          v_nxt     = {1'b0, r_r};
          state_nxt = S_LO_CHK;
        end
      end

      S_HI_Q2: begin
        lo_raddr   = dq_r[AW-1:0];
        sel_lo_nxt = 1'b1;
        state_nxt  = S_HI_SUB;
      end

      S_HI_SUB: begin
        cur_nxt   = sel_lo_r ? lo_rdata : hi_rdata;
        hi_raddr  = i_r[AW-1:0];
        state_nxt = S_HI_WR;
      end

      S_HI_WR: begin
        hi_we     = 1'b1;
        hi_waddr  = i_r[AW-1:0];
        hi_wdata  = hi_rdata - (cur_r - below_r);
        i_nxt     = i_r + (AW + 1)'(1);
        d_nxt     = d_r + W'(p_r);
        state_nxt = S_HI_CHK;
      end

      // low table pass over v from r down to p*p
      S_LO_CHK: begin
        if ((W + 1)'(v_r) >= sq_r) begin
          dq_nxt    = W'(v_r);
          drem_nxt  = '0;
          dden_nxt  = W'(p_r);
          cnt_nxt   = CNTW'(W);
          ret_nxt   = S_LO_Q;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_NEXT_P;
        end
      end

      S_LO_Q: begin
        lo_raddr  = dq_r[AW-1:0];
        state_nxt = S_LO_SUB;
      end

      S_LO_SUB: begin
        cur_nxt   = lo_rdata;
        lo_raddr  = v_r[AW-1:0];
        state_nxt = S_LO_WR;
      end

      S_LO_WR: begin
        lo_we     = 1'b1;
        lo_waddr  = v_r[AW-1:0];
        lo_wdata  = lo_rdata - (cur_r - below_r);
        v_nxt     = v_r - (AW + 1)'(1);
        state_nxt = S_LO_CHK;
      end

      // next candidate, square kept by adding 2p+1
      S_NEXT_P: begin
        p_nxt  = p_r + (AW + 1)'(1);
        sq_nxt = sq_r + (W + 1)'({p_r, 1'b1});
        if (p_r == {1'b0, r_r}) begin
          state_nxt = S_FIN_RD;
        end else begin
          state_nxt = S_P_RD0;
        end
      end

      // pi(n) sits in hi[1]
      S_FIN_RD: begin
        hi_raddr  = AW'(1);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        res_value_nxt = cnt_ext[OUT_WIDTH-1:0];
        state_nxt     = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // a failed or unsupported job never carries a value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_DONE) |-> (out_tdata == '0))
    else $error("nonzero value on a failed result");

  // the divider never runs on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dden_r != '0))
    else $error("divide by zero in sieve");

  // a job is taken only one at a time
  a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second job accepted while busy");

  // high table updates stay inside 1..r
  a_hi_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HI_WR) |-> ((i_r != '0) && (i_r <= {1'b0, r_r})))
    else $error("high table index out of range");

  // a waiting result holds the sequencer in its hand-off state
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_valid_r && !out_tready |=> (state_r == S_DONE))
    else $error("result hand-off lost");
`endif

endmodule
